>>> hw/rtl/radix_token_max_tracker_defines.svh
// Assertion macros shared by the radix token tracker RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef RADIX_TOKEN_MAX_TRACKER_DEFINES_SVH
`define RADIX_TOKEN_MAX_TRACKER_DEFINES_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define RTT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold on the cycle after.
`define RTT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/rtt_pkg.sv
// Package for the radix token tracker: widths, character codes, the token
// result type and the digit decode helpers. No dependencies.
package rtt_pkg;

	localparam int VALUE_BITS = 31;
	localparam int RADIX_W    = 6;
	localparam int CODE_W     = 8;
	localparam int DIGIT_W    = RADIX_W;
	localparam int PROD_W     = VALUE_BITS + RADIX_W;

	localparam logic [VALUE_BITS-1:0] VALUE_LIMIT = '1;

	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);

	localparam logic [CODE_W-1:0] CHAR_0  = 8'h30;
	localparam logic [CODE_W-1:0] CHAR_9  = 8'h39;
	localparam logic [CODE_W-1:0] CHAR_UA = 8'h41;
	localparam logic [CODE_W-1:0] CHAR_UZ = 8'h5A;
	localparam logic [CODE_W-1:0] CHAR_LA = 8'h61;
	localparam logic [CODE_W-1:0] CHAR_LZ = 8'h7A;

	localparam logic [CODE_W-1:0]  LETTER_BASE = CODE_W'(10);
	// Larger than any usable radix, so it always fails the digit check.
	localparam logic [DIGIT_W-1:0] NO_DIGIT    = '1;

	typedef struct packed {
		logic                  token_valid;
		logic [VALUE_BITS-1:0] token_value;
		logic                  overflowed;
	} tok_t;

	// Clamps the register contents to the supported range of bases.
	function automatic logic [RADIX_W-1:0] effective_radix(logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		if (r < RADIX_MIN) begin
			res = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			res = RADIX_MAX;
		end else begin
			res = r;
		end
		return res;
	endfunction

	// Digit value of a character, letters in either case counting from ten.
	function automatic logic [DIGIT_W-1:0] digit_of(logic [CODE_W-1:0] code);
		logic [CODE_W-1:0] tmp;
		case (code) inside
			[CHAR_0:CHAR_9]:   tmp = code - CHAR_0;
			[CHAR_UA:CHAR_UZ]: tmp = code - CHAR_UA + LETTER_BASE;
			[CHAR_LA:CHAR_LZ]: tmp = code - CHAR_LA + LETTER_BASE;
			default:           tmp = CODE_W'(NO_DIGIT);
		endcase
		return tmp[DIGIT_W-1:0];
	endfunction

endpackage

>>> hw/rtl/rtt_ifs.sv
// Handshake interfaces for the radix token tracker: character words,
// result words and the radix write channel. Depends on rtt_pkg.
interface rtt_char_if;
	import rtt_pkg::*;
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] char_code;
	logic              last_char;
	modport source(output valid, char_code, last_char, input ready);
	modport sink(input valid, char_code, last_char, output ready);
endinterface

interface rtt_result_if;
	import rtt_pkg::*;
	logic                  valid;
	logic                  ready;
	logic                  token_valid;
	logic [VALUE_BITS-1:0] token_value;
	logic                  overflowed;
	logic [VALUE_BITS-1:0] max_value;
	modport source(output valid, token_valid, token_value, overflowed, max_value,
		input ready);
	modport sink(input valid, token_valid, token_value, overflowed, max_value,
		output ready);
endinterface

interface rtt_cfg_if;
	import rtt_pkg::*;
	logic               valid;
	logic               ready;
	logic [RADIX_W-1:0] radix;
	modport source(output valid, radix, input ready);
	modport sink(input valid, radix, output ready);
endinterface

>>> hw/rtl/rtt_accum.sv
// Radix register, character input register and the multiply-add accumulator.
// Depends on rtt_pkg, rtt_ifs and radix_token_max_tracker_defines.svh.
`include "radix_token_max_tracker_defines.svh"

module rtt_accum (
	input  logic          clk,
	input  logic          arst_n,
	rtt_cfg_if.sink       cfg,
	rtt_char_if.sink      chars,
	output logic          tok_vld_s2,
	output rtt_pkg::tok_t tok_s2,
	input  logic          tok_ready
);
	import rtt_pkg::*;

	logic [RADIX_W-1:0]    radix_q;
	logic [CODE_W-1:0]     code_s1;
	logic                  last_s1;
	logic                  vld_s1;
	logic [VALUE_BITS-1:0] acc_q;
	logic                  bad_q;
	logic                  ovf_q;
	logic [RADIX_W-1:0]    eff_r;
	logic [DIGIT_W-1:0]    digit;
	logic [PROD_W-1:0]     product;
	logic [PROD_W-1:0]     sum;
	logic                  adv1;
	logic [VALUE_BITS-1:0] acc_nx;
	logic                  bad_nx;
	logic                  ovf_nx;
	tok_t                  tok_nx;

	assign cfg.ready = 1'b1;

	// A character that does not end a token never needs the result stage.
	assign adv1        = vld_s1 && (!last_s1 || !tok_vld_s2 || tok_ready);
	assign chars.ready = !vld_s1 || adv1;

	assign eff_r   = effective_radix(radix_q);
	assign digit   = digit_of(code_s1);
	assign product = PROD_W'(acc_q) * PROD_W'(eff_r);
	assign sum     = product + PROD_W'(digit);

	always_comb begin
		acc_nx = acc_q;
		bad_nx = bad_q;
		ovf_nx = ovf_q;
		if (digit >= eff_r) begin
			bad_nx = 1'b1;
		end else if (!bad_q) begin
			if (ovf_q || (|sum[PROD_W-1:VALUE_BITS])) begin
				acc_nx = VALUE_LIMIT;
				ovf_nx = 1'b1;
			end else begin
				acc_nx = sum[VALUE_BITS-1:0];
			end
		end
		tok_nx.token_valid = !bad_nx;
		tok_nx.token_value = bad_nx ? '0 : acc_nx;
		tok_nx.overflowed  = !bad_nx && ovf_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q    <= RADIX_RESET;
			vld_s1     <= 1'b0;
			tok_vld_s2 <= 1'b0;
			acc_q      <= '0;
			bad_q      <= 1'b0;
			ovf_q      <= 1'b0;
		end else begin
			if (cfg.valid) begin
				radix_q <= cfg.radix;
			end
			if (chars.ready) begin
				vld_s1 <= chars.valid;
			end
			if (adv1 && last_s1) begin
				tok_vld_s2 <= 1'b1;
			end else if (tok_ready) begin
				tok_vld_s2 <= 1'b0;
			end
			if (adv1) begin
				if (last_s1) begin
					acc_q <= '0;
					bad_q <= 1'b0;
					ovf_q <= 1'b0;
				end else begin
					acc_q <= acc_nx;
					bad_q <= bad_nx;
					ovf_q <= ovf_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			code_s1 <= chars.char_code;
			last_s1 <= chars.last_char;
		end
		if (adv1 && last_s1) begin
			tok_s2 <= tok_nx;
		end
	end

	`RTT_ASSERT_NOW(a_sat_value, ovf_q && !bad_q, acc_q == VALUE_LIMIT,
		"Saturated token does not hold the limit value")
	`RTT_ASSERT_NEXT(a_token_clear, adv1 && last_s1, acc_q == '0 && !bad_q && !ovf_q,
		"Token state not cleared after the last character")
	`RTT_ASSERT_NOW(a_invalid_zero, tok_vld_s2 && !tok_s2.token_valid,
		tok_s2.token_value == '0 && !tok_s2.overflowed,
		"Invalid token carries a value or an overflow flag")

endmodule

>>> hw/rtl/rtt_max_out.sv
// Running maximum of valid token values and the result output register.
// Depends on rtt_pkg, rtt_ifs and radix_token_max_tracker_defines.svh.
`include "radix_token_max_tracker_defines.svh"

module rtt_max_out (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          tok_vld,
	input  rtt_pkg::tok_t tok,
	output logic          tok_ready,
	rtt_result_if.source  results
);
	import rtt_pkg::*;

	logic                  out_vld_s3;
	tok_t                  tok_s3;
	logic [VALUE_BITS-1:0] largest_q;
	logic [VALUE_BITS-1:0] max_nx;
	logic                  load;

	assign tok_ready = !out_vld_s3 || results.ready;
	assign load      = tok_vld && tok_ready;
	assign max_nx    = (tok.token_valid && tok.token_value > largest_q) ?
		tok.token_value : largest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_s3 <= 1'b0;
			largest_q  <= '0;
		end else begin
			if (tok_ready) begin
				out_vld_s3 <= tok_vld;
			end
			if (load) begin
				largest_q <= max_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tok_s3 <= tok;
		end
	end

	// The maximum only changes on a load, so it stays matched to the held word.
	assign results.valid       = out_vld_s3;
	assign results.token_valid = tok_s3.token_valid;
	assign results.token_value = tok_s3.token_value;
	assign results.overflowed  = tok_s3.overflowed;
	assign results.max_value   = largest_q;

	`RTT_ASSERT_NOW(a_max_covers, out_vld_s3 && tok_s3.token_valid,
		largest_q >= tok_s3.token_value, "Maximum is below a valid token value")
	`RTT_ASSERT_NEXT(a_max_monotonic, 1'b1, largest_q >= $past(largest_q),
		"Running maximum decreased")
	`RTT_ASSERT_NEXT(a_load_shows, load, out_vld_s3,
		"Loaded token result is not presented")

endmodule

>>> hw/rtl/radix_token_max_tracker.sv
// Top level of the radix token tracker: joins the accumulator and the
// maximum/output stage. Depends on rtt_pkg, rtt_ifs, rtt_accum, rtt_max_out.
//
//  Channel   Dir  Payload                                          Word moved
//  cfg       in   radix (6b)                                       one per write
//  chars     in   char_code (8b), last_char (1b)                   one character
//  results   out  token_valid, token_value (31b), overflowed,      one per token
//                 max_value (31b)
//
// A character word is taken each cycle that chars.ready is high; the accumulator's
// 31x6 multiply-add and limit compare sit between the input and state registers.
// A token's result word goes to the token register and then the output register.
// Reset clears the token state and the maximum and sets the radix to ten.
// When results.ready is low the output word holds, the token register and the
// input register fill in turn, and chars.ready drops only once both are full;
// characters that do not end a token keep flowing while a result is held.
module radix_token_max_tracker (
	input  logic         clk,
	input  logic         arst_n,
	rtt_cfg_if.sink      cfg,
	rtt_char_if.sink     chars,
	rtt_result_if.source results
);
	import rtt_pkg::*;

	// Token result handed from the accumulator to the maximum stage.
	logic tok_vld_s2;
	tok_t tok_s2;
	logic tok_ready;

	// Digit decode, radix check and value build for each character word.
	rtt_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.chars      (chars),
		.tok_vld_s2 (tok_vld_s2),
		.tok_s2     (tok_s2),
		.tok_ready  (tok_ready)
	);

	// Running maximum over valid tokens and the registered result word.
	rtt_max_out u_max_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_vld   (tok_vld_s2),
		.tok       (tok_s2),
		.tok_ready (tok_ready),
		.results   (results)
	);

endmodule

>>> verif/radix_token_max_tracker_checker.sv
`timescale 1ns / 100ps
// Watching checker for radix_token_max_tracker: follows the radix, character and
// result channels, predicts every token result and compares it. Depends on rtt_pkg, rtt_ifs.
module radix_token_max_tracker_checker (
	input  logic   clk,
	input  logic   arst_n,
	rtt_cfg_if     cfg,
	rtt_char_if    chars,
	rtt_result_if  results,
	output int     error_count,
	output int     tokens_pending,
	output int     tokens_checked
);
	import rtt_pkg::*;

	localparam int unsigned NOT_A_DIGIT = 99;
	localparam int          REPORT_MAX  = 10;

	typedef struct packed {
		tok_t                  tok;
		logic [VALUE_BITS-1:0] max_value;
	} token_word_t;

	logic [RADIX_W-1:0]    radix_q  = RADIX_RESET;
	logic [VALUE_BITS-1:0] accum    = '0;
	logic                  bad_seen = 1'b0;
	logic                  sat_seen = 1'b0;
	logic [VALUE_BITS-1:0] peak     = '0;
	token_word_t           token_results_q[$];
	int                    errors   = 0;
	int                    checked  = 0;

	assign error_count    = errors;
	assign tokens_checked = checked;

	function automatic int unsigned clamp_base(logic [RADIX_W-1:0] r);
		if (r < RADIX_MIN) return 32'(RADIX_MIN);
		if (r > RADIX_MAX) return 32'(RADIX_MAX);
		return 32'(r);
	endfunction

	function automatic int unsigned digit_value(logic [CODE_W-1:0] code);
		if (code >= CHAR_0 && code <= CHAR_9) return 32'(code - CHAR_0);
		if (code >= CHAR_UA && code <= CHAR_UZ) return 32'(code - CHAR_UA + LETTER_BASE);
		if (code >= CHAR_LA && code <= CHAR_LZ) return 32'(code - CHAR_LA + LETTER_BASE);
		return NOT_A_DIGIT;
	endfunction

	// Folds one character into the running token and queues the result on its last one.
	task automatic fold_char(input logic [CODE_W-1:0] code, input logic last);
		int unsigned     base;
		int unsigned     dval;
		longint unsigned next_val;
		token_word_t     w;
		base = clamp_base(radix_q);
		dval = digit_value(code);
		if (dval >= base) begin
			bad_seen = 1'b1;
		end else if (!bad_seen) begin
			next_val = 64'(accum);
			next_val = next_val * base + dval;
			if (sat_seen || next_val > VALUE_LIMIT) begin
				accum    = VALUE_LIMIT;
				sat_seen = 1'b1;
			end else begin
				accum = next_val[VALUE_BITS-1:0];
			end
		end
		if (last) begin
			if (!bad_seen && accum > peak) peak = accum;
			w.tok.token_valid = !bad_seen;
			w.tok.token_value = bad_seen ? '0 : accum;
			w.tok.overflowed  = !bad_seen && sat_seen;
			w.max_value       = peak;
			token_results_q.push_back(w);
			accum    = '0;
			bad_seen = 1'b0;
			sat_seen = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		token_word_t want;
		if (!arst_n) begin
			radix_q  = RADIX_RESET;
			accum    = '0;
			bad_seen = 1'b0;
			sat_seen = 1'b0;
			peak     = '0;
			token_results_q.delete();
			tokens_pending <= 0;
		end else begin
			// A result word taken now belongs to an earlier token, so it is matched first.
			if (results.valid && results.ready) begin
				if (token_results_q.size() == 0) begin
					errors++;
					if (errors <= REPORT_MAX)
						$display({"%0t: result word with no token pending: ",
							"valid %0b value %0d ovf %0b max %0d"},
							$realtime, results.token_valid, results.token_value,
							results.overflowed, results.max_value);
				end else begin
					want = token_results_q.pop_front();
					checked++;
					if (results.token_valid !== want.tok.token_valid ||
						results.token_value !== want.tok.token_value ||
						results.overflowed !== want.tok.overflowed ||
						results.max_value !== want.max_value) begin
						errors++;
						if (errors <= REPORT_MAX) begin
							$display("%0t: token %0d mismatch", $realtime, checked);
							$display("  expected valid %0b value %0d ovf %0b max %0d",
								want.tok.token_valid, want.tok.token_value,
								want.tok.overflowed, want.max_value);
							$display("  actual   valid %0b value %0d ovf %0b max %0d",
								results.token_valid, results.token_value,
								results.overflowed, results.max_value);
						end
					end
				end
			end
			if (cfg.valid && cfg.ready) radix_q = cfg.radix;
			if (chars.valid && chars.ready) fold_char(chars.char_code, chars.last_char);
			tokens_pending <= token_results_q.size();
		end
	end

endmodule

>>> verif/radix_token_max_tracker_test.sv
`timescale 1ns / 100ps
// Top of the radix_token_max_tracker testbench: clock, reset, character and radix
// stimulus, result back-pressure and the verdict. Depends on rtt_pkg, rtt_ifs, the checker.
module radix_token_max_tracker_test;
	import rtt_pkg::*;

	// The limit leaves a wide margin for about nine hundred characters and the radix writes.
	localparam int CYCLE_LIMIT  = 200000;
	// Settling time after the last result word; it covers characters still in the
	// pipeline that end no token.
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASES       = 8;
	localparam int PHASE_CHARS  = 106;

	logic clk;
	logic arst_n;
	int   idle_odds = 4;     // chance of an idle burst is one in idle_odds; zero turns it off
	int   stall_left = 0;
	int   cycles = 0;
	int   chars_sent = 0;
	int   radix_writes = 0;
	int   error_count;
	int   tokens_pending;
	int   tokens_checked;

	rtt_cfg_if    cfg_if ();
	rtt_char_if   chars_if ();
	rtt_result_if result_if ();

	radix_token_max_tracker u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_if),
		.chars   (chars_if),
		.results (result_if)
	);

	radix_token_max_tracker_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_if),
		.chars          (chars_if),
		.results        (result_if),
		.error_count    (error_count),
		.tokens_pending (tokens_pending),
		.tokens_checked (tokens_checked)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Overall watchdog: a hung handshake or a lost result word ends here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d tokens pending.",
				cycles, tokens_pending);
			$display("radix_token_max_tracker_test: done, errors");
			$finish;
		end
	end

	// Result back-pressure. A stall burst drives ready low; stall_left counts the
	// cycles of the burst still to come.
	always @(posedge clk) begin
		if (idle_odds == 0) begin
			result_if.ready <= 1'b1;
		end else if (stall_left > 0) begin
			result_if.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, idle_odds - 1) == 0) begin
			result_if.ready <= 1'b0;
			stall_left <= $urandom_range(0, 7);
		end else begin
			result_if.ready <= 1'b1;
		end
	end

	// Offers one character word and returns at the edge that takes it. valid is
	// left high, so back-to-back words follow without a bubble; an idle burst
	// lowers it once and raises it again only at a later edge.
	task automatic send_char(input logic [CODE_W-1:0] code, input logic last);
		int gap;
		if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
			gap = $urandom_range(1, 8);
			chars_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars_if.valid     <= 1'b1;
		chars_if.char_code <= code;
		chars_if.last_char <= last;
		do @(posedge clk); while (!chars_if.ready);
		chars_sent++;
	endtask

	// Sends a string as characters; the final one ends the token if end_token is set.
	task automatic send_text(input string s, input logic end_token);
		int i;
		for (i = 0; i < s.len(); i++)
			send_char(s[i], end_token && (i == s.len() - 1));
	endtask

	// Waits until every expected result word has come out and the pipeline has
	// had time to settle, then writes the radix. A token left open stays open,
	// so its remaining characters are weighed with the new radix.
	task automatic write_radix(input logic [RADIX_W-1:0] r);
		chars_if.valid <= 1'b0;
		do @(posedge clk); while (tokens_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.radix <= r;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		radix_writes++;
	endtask

	// ASCII character for a digit value; letters come in either case at random.
	function automatic logic [CODE_W-1:0] digit_char(int unsigned d);
		if (d < LETTER_BASE) return CODE_W'(CHAR_0 + d);
		if ($urandom_range(0, 1) == 1) return CODE_W'(CHAR_LA + d - LETTER_BASE);
		return CODE_W'(CHAR_UA + d - LETTER_BASE);
	endfunction

	// One random phase under a single radix setting. Most characters are legal
	// digits so that tokens build real values; about one in twenty is any byte
	// at all. Early phases keep tokens short so the running maximum stays well
	// below the limit and is worth checking; later phases run tokens past the
	// point of saturation.
	task automatic run_phase(input int k, input logic [RADIX_W-1:0] r);
		int unsigned     base;
		int              need;
		int              cap;
		int              len;
		int              sent;
		int              i;
		longint unsigned span;
		logic [CODE_W-1:0] code;
		write_radix(r);
		// Gaps on both sides in most phases, a stretch without in phase two and the last.
		idle_odds <= (k == 2 || k == PHASES - 1) ? 0 : ((k % 2 == 1) ? 3 : 6);
		base = 32'((r < RADIX_MIN) ? RADIX_MIN : ((r > RADIX_MAX) ? RADIX_MAX : r));
		need = 0;
		span = 1;
		while (span <= VALUE_LIMIT) begin
			span = span * base;
			need++;
		end
		cap  = (k < PHASES / 2) ? ((need / 2 > 1) ? need / 2 : 1) : need + 2;
		sent = 0;
		while (sent < PHASE_CHARS) begin
			len = $urandom_range(1, cap);
			for (i = 0; i < len; i++) begin
				if ($urandom_range(0, 19) == 0) code = CODE_W'($urandom_range(0, 255));
				else code = digit_char($urandom_range(0, base - 1));
				send_char(code, i == len - 1);
			end
			sent += len;
		end
		// Now and then leave a token open across the next radix write.
		if (k < PHASES - 1 && $urandom_range(0, 1) == 1) begin
			len = $urandom_range(1, 2);
			for (i = 0; i < len; i++)
				send_char(digit_char($urandom_range(0, base - 1)), 1'b0);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_if.valid       <= 1'b0;
		cfg_if.radix       <= RADIX_RESET;
		chars_if.valid     <= 1'b0;
		chars_if.char_code <= '0;
		chars_if.last_char <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words under the reset radix of ten: zero, a plain number, a
		// letter just out of range, the all-ones and all-zeros bytes, and the
		// codes on either side of the decimal digits.
		send_text("0", 1'b1);
		send_text("99", 1'b1);
		send_text("a", 1'b1);
		send_char(8'hFF, 1'b0);
		send_char(8'h00, 1'b1);
		send_text("/:", 1'b1);

		// Radix 36: top letters in both cases, the codes on either side of the lower-case
		// range, and a token that saturates and then turns invalid.
		write_radix(RADIX_MAX);
		send_text("Zz", 1'b1);
		send_text("`{", 1'b1);
		send_text("zzzzzz@", 1'b1);

		// A radix of zero acts as two. The open token then picks up radix 63,
		// which acts as 36, for its last character.
		write_radix('0);
		send_text("101", 1'b1);
		send_text("1", 1'b0);
		write_radix('1);
		send_text("Y", 1'b1);

		// Just past the top of the range, then one below the bottom.
		write_radix(RADIX_MAX + 1'b1);
		send_text("A", 1'b1);
		write_radix(RADIX_MIN - 1'b1);
		send_text("2", 1'b1);

		// Random phases; the radix list covers both ends, values outside the
		// range on each side, and random settings.
		run_phase(0, RADIX_MIN);
		run_phase(1, RADIX_MAX);
		run_phase(2, RADIX_W'($urandom_range(3, 35)));
		run_phase(3, RADIX_MAX + 1'b1);
		run_phase(4, RADIX_MIN - 1'b1);
		run_phase(5, 6'd16);
		run_phase(6, RADIX_W'($urandom_range(0, 63)));
		run_phase(7, RADIX_RESET);

		chars_if.valid <= 1'b0;
		do @(posedge clk); while (tokens_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d characters under %0d radix settings; %0d token results compared.",
			chars_sent, radix_writes + 1, tokens_checked);
		$display("Tokens spanned legal, illegal and saturating digits, upper and lower case.");
		if (error_count == 0 && tokens_pending == 0) begin
			$display("radix_token_max_tracker_test: done, clean");
		end else begin
			$display("radix_token_max_tracker_test: done, errors");
		end
		$finish;
	end

endmodule
